>>> hdl/rclfr_pkg.sv
// ----------------------------------------------------------------------------
// rclfr_pkg
// Shared types and constants for the RC link frame receiver.
// ----------------------------------------------------------------------------
package rclfr_pkg;

    localparam int NUM_CHANNELS     = 16;
    localparam int CHANNEL_BITS     = 11;
    localparam int MAX_FRAME_LENGTH = 62;

    localparam int PAYLOAD_START = 3;
    localparam int STORE_DEPTH   = PAYLOAD_START + (NUM_CHANNELS * CHANNEL_BITS + 7) / 8;
    localparam int STORE_AW      = $clog2(STORE_DEPTH + 1);
    localparam int CH_W          = 4;
    localparam int ACC_W         = CHANNEL_BITS + 7;
    localparam int NBITS_W       = $clog2(ACC_W + 1);
    localparam int POS_W         = 7;
    localparam int LEN_W         = 6;

    localparam logic [7:0] CRC_POLY         = 8'hD5;
    localparam logic [7:0] SYNC_FC          = 8'hC8;
    localparam logic [7:0] SYNC_RX          = 8'hEA;
    localparam logic [7:0] SYNC_TX          = 8'hEE;
    localparam logic [7:0] TYPE_RC_CHANNELS = 8'h16;
    localparam logic [7:0] MIN_LEN          = 8'd2;
    localparam logic [7:0] MAX_LEN          = 8'(MAX_FRAME_LENGTH);

    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE   = 2'd0,
        SQ_CRC    = 2'd1,
        SQ_DECODE = 2'd2,
        SQ_EMIT   = 2'd3
    } t_seq;

    typedef struct packed {
        logic       clear;
        logic       load;
        logic [7:0] data;
    } t_crc_ctl;

    typedef struct packed {
        logic       busy;
        logic [7:0] crc;
    } t_crc_sts;

endpackage

>>> hdl/rc_link_frame_receiver.sv
// ----------------------------------------------------------------------------
// rc_link_frame_receiver
// Parses sync/length/type/payload/CRC frames from a byte stream and emits the
// 16 stored RC channels after every good frame.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields
// s_axis    in   tdata[7:0] rx_byte
// m_axis    out  tdata: address, type, index, value; tuser: updated; tlast
//
// Sync and length words are taken directly; type and payload words wait for the
// bit-serial CRC unit. A good frame of type 0x16 is decoded into the channel
// store; then 16 words go out at one per cycle while downstream is ready.
// Synchronous active-low reset clears parser, frame store and channel store.
// s_axis is not ready during CRC work, channel decode or a run being sent.
// ----------------------------------------------------------------------------
module rc_link_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] frame_address, [15:8] frame_type,
                                     // [19:16] channel_index, [30:20] channel_value
    output logic        o_m_tuser,   // [0] channels_updated
    output logic        o_m_tlast    // last
);

    localparam int NCH   = rclfr_pkg::NUM_CHANNELS;
    localparam int CHB   = rclfr_pkg::CHANNEL_BITS;
    localparam int DEPTH = rclfr_pkg::STORE_DEPTH;
    localparam int AW    = rclfr_pkg::STORE_AW;

    rclfr_pkg::t_phase r_phase, n_phase;
    rclfr_pkg::t_seq   r_seq, n_seq;

    logic [rclfr_pkg::LEN_W-1:0]   r_len, n_len;
    logic [rclfr_pkg::POS_W-1:0]   r_pos, n_pos;
    logic                          r_upd, n_upd;
    logic [rclfr_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [rclfr_pkg::NBITS_W-1:0] r_nbits, n_nbits;
    logic [AW-1:0]                 r_rd_addr, n_rd_addr;
    logic [rclfr_pkg::CH_W-1:0]    r_ch, n_ch;

    logic [7:0]     r_store [DEPTH];
    logic [CHB-1:0] r_chan  [NCH];

    logic           w_st_we;
    logic [AW-1:0]  w_st_idx;
    logic           w_ch_we;
    logic [7:0]     w_rd_byte;
    logic           w_acc;
    logic           w_out_acc;

    rclfr_pkg::t_crc_ctl w_crc_ctl;
    rclfr_pkg::t_crc_sts w_crc_sts;

    rclfr_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .o_sts   (w_crc_sts)
    );

    assign o_s_tready = (r_seq == rclfr_pkg::SQ_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_seq == rclfr_pkg::SQ_EMIT);
    assign w_out_acc  = o_m_tvalid && i_m_tready;

    assign w_rd_byte = (r_rd_addr < AW'(DEPTH)) ? r_store[r_rd_addr] : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rclfr_pkg::PH_SYNC;
            r_seq     <= rclfr_pkg::SQ_IDLE;
            r_len     <= '0;
            r_pos     <= '0;
            r_upd     <= 1'b0;
            r_acc     <= '0;
            r_nbits   <= '0;
            r_rd_addr <= '0;
            r_ch      <= '0;
        end else begin
            r_phase   <= n_phase;
            r_seq     <= n_seq;
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_upd     <= n_upd;
            r_acc     <= n_acc;
            r_nbits   <= n_nbits;
            r_rd_addr <= n_rd_addr;
            r_ch      <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_store[i] <= 8'd0;
            end
        end else if (w_st_we) begin
            r_store[w_st_idx] <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_chan[i] <= '0;
            end
        end else if (w_ch_we) begin
            r_chan[r_ch] <= r_acc[CHB-1:0];
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_seq     = r_seq;
        n_len     = r_len;
        n_pos     = r_pos;
        n_upd     = r_upd;
        n_acc     = r_acc;
        n_nbits   = r_nbits;
        n_rd_addr = r_rd_addr;
        n_ch      = r_ch;
        w_st_we   = 1'b0;
        w_st_idx  = '0;
        w_ch_we   = 1'b0;
        w_crc_ctl = '0;

        case (r_seq)
            rclfr_pkg::SQ_IDLE: begin
                if (w_acc) begin
                    case (r_phase)
                        rclfr_pkg::PH_LEN: begin
                            if (i_s_tdata < rclfr_pkg::MIN_LEN
                                    || i_s_tdata > rclfr_pkg::MAX_LEN) begin
                                n_phase = rclfr_pkg::PH_SYNC;
                            end else begin
                                w_st_we         = 1'b1;
                                w_st_idx        = AW'(1);
                                n_len           = i_s_tdata[rclfr_pkg::LEN_W-1:0];
                                n_pos           = rclfr_pkg::POS_W'(2);
                                w_crc_ctl.clear = 1'b1;
                                n_phase         = rclfr_pkg::PH_BODY;
                            end
                        end
                        rclfr_pkg::PH_BODY: begin
                            if (r_pos < rclfr_pkg::POS_W'(DEPTH)) begin
                                w_st_we  = 1'b1;
                                w_st_idx = r_pos[AW-1:0];
                            end
                            n_pos = r_pos + 1'b1;
                            if (r_pos < ({1'b0, r_len} + 1'b1)) begin
                                w_crc_ctl.load = 1'b1;
                                w_crc_ctl.data = i_s_tdata;
                                n_seq          = rclfr_pkg::SQ_CRC;
                            end else begin
                                n_phase = rclfr_pkg::PH_SYNC;
                                if (w_crc_sts.crc == i_s_tdata) begin
                                    n_upd = (r_store[2] == rclfr_pkg::TYPE_RC_CHANNELS);
                                    n_ch  = '0;
                                    if (r_store[2] == rclfr_pkg::TYPE_RC_CHANNELS) begin
                                        n_acc     = '0;
                                        n_nbits   = '0;
                                        n_rd_addr = AW'(rclfr_pkg::PAYLOAD_START);
                                        n_seq     = rclfr_pkg::SQ_DECODE;
                                    end else begin
                                        n_seq = rclfr_pkg::SQ_EMIT;
                                    end
                                end
                            end
                        end
                        default: begin
                            if (i_s_tdata inside {rclfr_pkg::SYNC_FC, rclfr_pkg::SYNC_RX,
                                                  rclfr_pkg::SYNC_TX}) begin
                                w_st_we  = 1'b1;
                                w_st_idx = '0;
                                n_phase  = rclfr_pkg::PH_LEN;
                            end else begin
                                n_phase = rclfr_pkg::PH_SYNC;
                            end
                        end
                    endcase
                end
            end
            rclfr_pkg::SQ_CRC: begin
                if (!w_crc_sts.busy) begin
                    n_seq = rclfr_pkg::SQ_IDLE;
                end
            end
            rclfr_pkg::SQ_DECODE: begin
                if (r_nbits >= rclfr_pkg::NBITS_W'(CHB)) begin
                    w_ch_we = 1'b1;
                    n_acc   = r_acc >> CHB;
                    n_nbits = r_nbits - rclfr_pkg::NBITS_W'(CHB);
                    n_ch    = r_ch + 1'b1;
                    if (r_ch == rclfr_pkg::CH_W'(NCH - 1)) begin
                        n_ch  = '0;
                        n_seq = rclfr_pkg::SQ_EMIT;
                    end
                end else begin
                    n_acc     = r_acc | (rclfr_pkg::ACC_W'(w_rd_byte) << r_nbits);
                    n_nbits   = r_nbits + rclfr_pkg::NBITS_W'(8);
                    n_rd_addr = r_rd_addr + 1'b1;
                end
            end
            rclfr_pkg::SQ_EMIT: begin
                if (w_out_acc) begin
                    n_ch = r_ch + 1'b1;
                    if (r_ch == rclfr_pkg::CH_W'(NCH - 1)) begin
                        n_ch  = '0;
                        n_seq = rclfr_pkg::SQ_IDLE;
                    end
                end
            end
            default: begin
                n_seq = rclfr_pkg::SQ_IDLE;
            end
        endcase
    end

    assign o_m_tdata = {1'b0, r_chan[r_ch], r_ch, r_store[2], r_store[0]};
    assign o_m_tuser = r_upd;
    assign o_m_tlast = (r_ch == rclfr_pkg::CH_W'(NCH - 1));

`ifndef NO_ASSERTIONS
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while a run is being sent");

    a_crc_busy_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_crc_sts.busy |-> (r_seq == rclfr_pkg::SQ_CRC))
        else $error("crc unit busy outside crc phase");

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == rclfr_pkg::SQ_DECODE) |-> (r_nbits <= rclfr_pkg::NBITS_W'(rclfr_pkg::ACC_W)))
        else $error("decode accumulator overflow");

    a_run_end_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_tlast) |=> o_s_tready)
        else $error("not ready after end of run");

    a_decode_store_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ch_we |-> r_upd)
        else $error("channel store written on a non-channel frame");
`endif

endmodule

>>> hdl/rclfr_crc_unit.sv
// ----------------------------------------------------------------------------
// rclfr_crc_unit
// Bit-serial CRC-8 (poly 0xD5, MSB first): one shift per cycle, 8 per word.
// ----------------------------------------------------------------------------
module rclfr_crc_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rclfr_pkg::t_crc_ctl i_ctl,
    output rclfr_pkg::t_crc_sts o_sts
);

    logic [7:0] r_crc;
    logic [3:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 8'd0;
            r_cnt <= 4'd0;
        end else if (i_ctl.clear) begin
            r_crc <= 8'd0;
            r_cnt <= 4'd0;
        end else if (i_ctl.load) begin
            r_crc <= r_crc ^ i_ctl.data;
            r_cnt <= 4'd8;
        end else if (r_cnt != 4'd0) begin
            r_crc <= r_crc[7] ? ({r_crc[6:0], 1'b0} ^ rclfr_pkg::CRC_POLY)
                              : {r_crc[6:0], 1'b0};
            r_cnt <= r_cnt - 4'd1;
        end
    end

    assign o_sts.busy = (r_cnt != 4'd0);
    assign o_sts.crc  = r_crc;

endmodule
